### rtl/ovs_pkg.sv
// Shared types, codes and constants of the oriented voxel stamp unit.
package ovs_pkg;

    localparam int CHUNK_EDGE_DEF = 16;
    localparam int ADDR_W_MAX     = 15;
    localparam int QUEUE_DEPTH    = 2;
    localparam int FLIP_X_BIT     = 2;

    localparam logic [1:0] MODE_STAMP = 2'd0;
    localparam logic [1:0] MODE_LOAD  = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    localparam logic [1:0] TURN_0   = 2'd0;
    localparam logic [1:0] TURN_90  = 2'd1;
    localparam logic [1:0] TURN_180 = 2'd2;
    localparam logic [1:0] TURN_270 = 2'd3;

    localparam logic [2:0] CFG_PLACE_X     = 3'd0;
    localparam logic [2:0] CFG_PLACE_Y     = 3'd1;
    localparam logic [2:0] CFG_PLACE_Z     = 3'd2;
    localparam logic [2:0] CFG_ORIENTATION = 3'd3;
    localparam logic [2:0] CFG_ANCHOR_X    = 3'd4;
    localparam logic [2:0] CFG_ANCHOR_Y    = 3'd5;
    localparam logic [2:0] CFG_ANCHOR_Z    = 3'd6;

    localparam logic [2:0] STAT_PLACED   = 3'd0;
    localparam logic [2:0] STAT_OUTSIDE  = 3'd1;
    localparam logic [2:0] STAT_OCCUPIED = 3'd2;
    localparam logic [2:0] STAT_LOADED   = 3'd3;
    localparam logic [2:0] STAT_READ     = 3'd4;

    localparam logic [1:0] OP_PLACE  = 2'd0;
    localparam logic [1:0] OP_LOAD   = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_REJECT = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  cell_x;
        logic [7:0]  cell_y;
        logic [7:0]  cell_z;
        logic [7:0]  block_value;
        logic [11:0] entry_index;
        logic        last_cell;
    } t_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [11:0] target_index;
        logic [7:0]  read_value;
        logic [15:0] placed_total;
        logic        stamp_done;
    } t_result;

    typedef struct packed {
        logic [1:0]            op;
        logic [ADDR_W_MAX-1:0] addr;
        logic [7:0]            value;
        logic                  done;
    } t_job;

    typedef struct packed {
        logic        clearing;
        logic [15:0] placed;
    } t_back_stat;

endpackage

### rtl/ovs_fifo.sv
// Small first-in first-out queue used between the unit's stages.
module ovs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = ovs_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_data [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             w_push, w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_data[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_data[r_wr_ptr] <= i_data;
        end
    end

endmodule

### rtl/ovs_front.sv
// Front end: placement registers, orientation transform and classification of each item.
module ovs_front #(
    parameter int CHUNK_EDGE = ovs_pkg::CHUNK_EDGE_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic [2:0]         i_cfg_index,
    input  logic [10:0]        i_cfg_data,
    input  ovs_pkg::t_item     i_item,
    output ovs_pkg::t_job      o_job
);
    localparam int STORE = CHUNK_EDGE * CHUNK_EDGE * CHUNK_EDGE;
    localparam int AW    = $clog2(STORE);
    localparam int CW    = $clog2(CHUNK_EDGE);
    localparam int JW    = ovs_pkg::ADDR_W_MAX;
    localparam logic [AW-1:0] PLANE = AW'(CHUNK_EDGE * CHUNK_EDGE);
    localparam logic [AW-1:0] ROW   = AW'(CHUNK_EDGE);

    logic signed [10:0] r_place_x, r_place_y, r_place_z;
    logic [2:0]         r_orient;
    logic [7:0]         r_anchor_x, r_anchor_y, r_anchor_z;

    logic signed [9:0]  w_dx, w_dz, w_dy, w_mx, w_ox, w_oz;
    logic signed [11:0] w_lx, w_ly, w_lz;
    logic               w_inside;
    logic [AW-1:0]      w_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_place_x  <= '0;
            r_place_y  <= '0;
            r_place_z  <= '0;
            r_orient   <= '0;
            r_anchor_x <= '0;
            r_anchor_y <= '0;
            r_anchor_z <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ovs_pkg::CFG_PLACE_X:     r_place_x  <= i_cfg_data;
                ovs_pkg::CFG_PLACE_Y:     r_place_y  <= i_cfg_data;
                ovs_pkg::CFG_PLACE_Z:     r_place_z  <= i_cfg_data;
                ovs_pkg::CFG_ORIENTATION: r_orient   <= i_cfg_data[2:0];
                ovs_pkg::CFG_ANCHOR_X:    r_anchor_x <= i_cfg_data[7:0];
                ovs_pkg::CFG_ANCHOR_Y:    r_anchor_y <= i_cfg_data[7:0];
                ovs_pkg::CFG_ANCHOR_Z:    r_anchor_z <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_dx = $signed({2'b00, i_item.cell_x}) - $signed({2'b00, r_anchor_x});
        w_dy = $signed({2'b00, i_item.cell_y}) - $signed({2'b00, r_anchor_y});
        w_dz = $signed({2'b00, i_item.cell_z}) - $signed({2'b00, r_anchor_z});
        w_mx = r_orient[ovs_pkg::FLIP_X_BIT] ? -w_dx : w_dx;
        case (r_orient[1:0])
            ovs_pkg::TURN_90: begin
                w_ox = -w_dz;
                w_oz = w_mx;
            end
            ovs_pkg::TURN_180: begin
                w_ox = -w_mx;
                w_oz = -w_dz;
            end
            ovs_pkg::TURN_270: begin
                w_ox = w_dz;
                w_oz = -w_mx;
            end
            default: begin
                w_ox = w_mx;
                w_oz = w_dz;
            end
        endcase
        w_lx = 12'(r_place_x) + 12'(w_ox);
        w_ly = 12'(r_place_y) + 12'(w_dy);
        w_lz = 12'(r_place_z) + 12'(w_oz);
        w_inside = !w_lx[11] && (w_lx < 12'(CHUNK_EDGE))
                && !w_ly[11] && (w_ly < 12'(CHUNK_EDGE))
                && !w_lz[11] && (w_lz < 12'(CHUNK_EDGE));
        w_idx = AW'(w_lx[CW-1:0]) * PLANE + AW'(w_ly[CW-1:0]) * ROW + AW'(w_lz[CW-1:0]);

        o_job.value = i_item.block_value;
        o_job.done  = 1'b0;
        o_job.addr  = '0;
        o_job.op    = ovs_pkg::OP_REJECT;
        case (i_item.mode)
            ovs_pkg::MODE_STAMP: begin
                o_job.done = i_item.last_cell;
                if (w_inside) begin
                    o_job.op   = ovs_pkg::OP_PLACE;
                    o_job.addr = JW'(w_idx);
                end
            end
            ovs_pkg::MODE_LOAD: begin
                if (32'(i_item.entry_index) < STORE) begin
                    o_job.op   = ovs_pkg::OP_LOAD;
                    o_job.addr = JW'(i_item.entry_index);
                end
            end
            ovs_pkg::MODE_READ: begin
                if (32'(i_item.entry_index) < STORE) begin
                    o_job.op   = ovs_pkg::OP_READ;
                    o_job.addr = JW'(i_item.entry_index);
                end
            end
            default: begin
            end
        endcase
    end

endmodule

### rtl/ovs_back.sv
// Back end: voxel store, clearing pass, read-modify-write and placement counter.
module ovs_back #(
    parameter int CHUNK_EDGE = ovs_pkg::CHUNK_EDGE_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ovs_pkg::t_job       i_job,
    input  logic                i_job_valid,
    output logic                o_job_pop,
    input  logic                i_res_full,
    output logic                o_res_push,
    output ovs_pkg::t_result    o_result,
    output ovs_pkg::t_back_stat o_stat
);
    localparam int STORE = CHUNK_EDGE * CHUNK_EDGE * CHUNK_EDGE;
    localparam int AW    = $clog2(STORE);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [7:0]    r_mem [STORE];
    logic [7:0]    r_rd;
    logic [1:0]    r_state, n_state;
    logic [AW-1:0] r_clr, n_clr;
    logic [15:0]   r_count, n_count;
    ovs_pkg::t_job r_job, n_job;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [7:0]    w_wdata;

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_count    = r_count;
        n_job      = r_job;
        o_job_pop  = 1'b0;
        o_res_push = 1'b0;
        w_we       = 1'b0;
        w_waddr    = r_job.addr[AW-1:0];
        w_wdata    = r_job.value;
        o_result.status       = ovs_pkg::STAT_OUTSIDE;
        o_result.target_index = r_job.addr[11:0];
        o_result.read_value   = '0;
        o_result.stamp_done   = r_job.done;
        case (r_state)
            ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = '0;
                n_clr   = r_clr + 1'b1;
                if (r_clr == AW'(STORE - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_job_valid && !i_res_full) begin
                    o_job_pop = 1'b1;
                    n_job     = i_job;
                    n_state   = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_res_push = 1'b1;
                n_state    = ST_IDLE;
                case (r_job.op)
                    ovs_pkg::OP_PLACE: begin
                        if (r_rd != '0) begin
                            o_result.status = ovs_pkg::STAT_OCCUPIED;
                        end else begin
                            o_result.status = ovs_pkg::STAT_PLACED;
                            w_we = 1'b1;
                            if (r_count != 16'hFFFF) begin
                                n_count = r_count + 1'b1;
                            end
                        end
                    end
                    ovs_pkg::OP_LOAD: begin
                        o_result.status = ovs_pkg::STAT_LOADED;
                        w_we = 1'b1;
                    end
                    ovs_pkg::OP_READ: begin
                        o_result.status     = ovs_pkg::STAT_READ;
                        o_result.read_value = r_rd;
                    end
                    default: begin
                        o_result.target_index = '0;
                    end
                endcase
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        o_result.placed_total = n_count;
    end

    assign o_stat.clearing = (r_state == ST_CLEAR);
    assign o_stat.placed   = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[i_job.addr[AW-1:0]];
    end

endmodule

### rtl/oriented_voxel_stamp_unit.sv
// Top level of the oriented voxel stamp unit: queues, front end and back end.
// After reset the unit clears its CHUNK_EDGE^3 voxel store one entry per cycle
// and holds full high meanwhile; configuration writes are taken at any time.
// The front end transforms and classifies a beat in the cycle it is accepted
// and places it in a two-entry queue. The back end owns the voxel store: in
// its idle state it takes a job, if the result queue has room, and reads the
// voxel into a register; in its execute state it writes the voxel and emits
// the result, and only then returns to idle, so it takes no new item before
// it is through with the last one.
module oriented_voxel_stamp_unit #(
    parameter int CHUNK_EDGE = ovs_pkg::CHUNK_EDGE_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  ovs_pkg::t_item   i_item,
    output logic             empty,
    input  logic             pop,
    output ovs_pkg::t_result o_result,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [2:0]       i_cfg_index,
    input  logic [10:0]      i_cfg_data
);
    localparam int JOB_W = $bits(ovs_pkg::t_job);
    localparam int RES_W = $bits(ovs_pkg::t_result);

    ovs_pkg::t_job       w_job_in, w_job_out;
    ovs_pkg::t_result    w_res_in;
    ovs_pkg::t_back_stat w_stat;
    logic                w_jq_full, w_jq_empty, w_job_pop;
    logic                w_res_full, w_res_push, w_accept;

    assign o_cfg_ready = 1'b1;
    assign full        = w_jq_full || w_stat.clearing;
    assign w_accept    = push && !full;

    ovs_front #(
        .CHUNK_EDGE(CHUNK_EDGE)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_item),
        .o_job      (w_job_in)
    );

    ovs_fifo #(
        .WIDTH(JOB_W),
        .DEPTH(ovs_pkg::QUEUE_DEPTH)
    ) u_job_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_accept),
        .i_data (w_job_in),
        .i_pop  (w_job_pop),
        .o_data (w_job_out),
        .o_full (w_jq_full),
        .o_empty(w_jq_empty)
    );

    ovs_back #(
        .CHUNK_EDGE(CHUNK_EDGE)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (w_job_out),
        .i_job_valid(!w_jq_empty),
        .o_job_pop  (w_job_pop),
        .i_res_full (w_res_full),
        .o_res_push (w_res_push),
        .o_result   (w_res_in),
        .o_stat     (w_stat)
    );

    ovs_fifo #(
        .WIDTH(RES_W),
        .DEPTH(ovs_pkg::QUEUE_DEPTH)
    ) u_res_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_res_push),
        .i_data (w_res_in),
        .i_pop  (pop),
        .o_data (o_result),
        .o_full (w_res_full),
        .o_empty(empty)
    );

    // A result is never pushed into a full result queue.
    a_res_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_push |-> !w_res_full)
        else $error("result pushed into a full queue");

    // No beat is taken while the store is being cleared.
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.clearing |-> (full && !w_res_push && !w_job_pop))
        else $error("activity during clearing pass");

    // The placement counter only ever steps up by one.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (w_stat.placed == $past(w_stat.placed)
                         || w_stat.placed == $past(w_stat.placed) + 16'd1))
        else $error("placement counter jumped");

endmodule
